@@ hdl/tmh_pkg.sv @@
// shared types, widths and codes for the timer min-heap
package tmh_pkg;
    localparam int ID_W      = 8;
    localparam int EXP_W     = 32;
    localparam int NUM_IDS   = 256;
    localparam int DEF_MAX_TIMERS = 256;

    typedef logic [ID_W-1:0]  t_id;
    typedef logic [EXP_W-1:0] t_exp;
    typedef logic [1:0]       t_cmd;
    typedef logic [1:0]       t_status;

    localparam t_cmd CMD_INSERT = 2'd0;
    localparam t_cmd CMD_REMOVE = 2'd1;
    localparam t_cmd CMD_UPDATE = 2'd2;

    localparam t_status ST_DONE    = 2'd0;
    localparam t_status ST_PRESENT = 2'd1;
    localparam t_status ST_ABSENT  = 2'd2;
    localparam t_status ST_FULL    = 2'd3;
endpackage

@@ hdl/timer_min_heap.sv @@
// timer min-heap: indexed binary heap of timers ordered by expiry tick
//
// input channel i_valid / o_stall carries one command transaction: insert,
// remove or update the expiry of a timer id. o_stall is high from the cycle
// after a transaction is accepted until its result has been taken.
// output channel o_valid / i_stall returns one result per command: a status,
// the earliest timer (id and expiry) and the number of timers held.
// one heap sequencer walks the tree with one read of each memory per cycle
// (slot ids, expiry per id, slot per id, all with registered read data)
// and one expiry compare per level moved up, up to two per level moved down
// (left and right child). items are handled one at a time: the next command
// is taken only once the result has been taken and the sequencer is idle.
// reset clears the presence flags and the count, so the heap starts empty;
// the memories need no clearing.
// while i_stall is high the result holds and no new command is taken.
module timer_min_heap #(
    parameter int MAX_TIMERS = tmh_pkg::DEF_MAX_TIMERS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  tmh_pkg::t_cmd                      i_cmd,
    input  tmh_pkg::t_id                       i_timer_id,
    input  tmh_pkg::t_exp                      i_expiry,
    output logic                               o_valid,
    input  logic                               i_stall,
    output tmh_pkg::t_status                   o_status,
    output logic                               o_head_valid,
    output tmh_pkg::t_id                       o_head_id,
    output tmh_pkg::t_exp                      o_head_expiry,
    output logic [$clog2(MAX_TIMERS+1)-1:0]    o_count
);
    import tmh_pkg::*;

    localparam int SW = $clog2(MAX_TIMERS);
    localparam int CW = $clog2(MAX_TIMERS+1);
    localparam int LW = SW + 2;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_POS    = 5'd1;
    localparam logic [4:0] S_MVID   = 5'd2;
    localparam logic [4:0] S_MVEXP  = 5'd3;
    localparam logic [4:0] S_RESIFT = 5'd4;
    localparam logic [4:0] S_UP_A   = 5'd5;
    localparam logic [4:0] S_UP_B   = 5'd6;
    localparam logic [4:0] S_UP_C   = 5'd7;
    localparam logic [4:0] S_DN_A   = 5'd8;
    localparam logic [4:0] S_DN_B   = 5'd9;
    localparam logic [4:0] S_DN_C   = 5'd10;
    localparam logic [4:0] S_DN_D   = 5'd11;
    localparam logic [4:0] S_DN_E   = 5'd12;
    localparam logic [4:0] S_DN_F   = 5'd13;
    localparam logic [4:0] S_PLACE  = 5'd14;
    localparam logic [4:0] S_HEAD   = 5'd15;
    localparam logic [4:0] S_HEAD_B = 5'd16;
    localparam logic [4:0] S_HEAD_C = 5'd17;
    localparam logic [4:0] S_OUT    = 5'd18;

    // memories
    t_id            slot_mem [MAX_TIMERS];
    t_exp           exp_mem  [NUM_IDS];
    logic [SW-1:0]  pos_mem  [NUM_IDS];

    logic [4:0]          r_state, n_state;
    logic [NUM_IDS-1:0]  r_present, n_present;
    logic [CW-1:0]       r_cnt, n_cnt;
    t_cmd                r_cmd, n_cmd;
    t_id                 r_id, n_id;
    t_exp                r_exp, n_exp;
    logic [SW-1:0]       r_pos, n_pos;
    t_id                 r_cur_id, n_cur_id;
    t_exp                r_cur_exp, n_cur_exp;
    logic                r_tryup, n_tryup;
    t_id                 r_oid, n_oid;
    t_id                 r_best_id, n_best_id;
    t_exp                r_best_exp, n_best_exp;
    logic [SW-1:0]       r_best_pos, n_best_pos;
    logic                r_has, n_has;
    t_status             r_status, n_status;
    logic                r_hvalid, n_hvalid;
    t_id                 r_hid, n_hid;
    t_exp                r_hexp, n_hexp;

    t_id            r_slot_q;
    t_exp           r_exp_q;
    logic [SW-1:0]  r_pos_q;

    logic           slot_we;
    logic [SW-1:0]  slot_waddr, slot_raddr;
    t_id            slot_wdata;
    logic           exp_we;
    t_id            exp_waddr, exp_raddr;
    t_exp           exp_wdata;
    logic           pos_we;
    t_id            pos_waddr;
    logic [SW-1:0]  pos_wdata;

    logic [SW-1:0]  parent;
    logic [LW-1:0]  lft, rgt, cnt_x, pos_x;
    logic [SW-1:0]  last;
    logic           accept;

    assign accept = i_valid && (r_state == S_IDLE);
    assign parent = (r_pos - SW'(1)) >> 1;
    assign lft    = {1'b0, r_pos, 1'b1};
    assign rgt    = lft + LW'(1);
    assign cnt_x  = LW'(r_cnt);
    assign pos_x  = LW'(r_pos_q);
    assign last   = SW'(r_cnt - CW'(1));

    always_comb begin
        n_state    = r_state;
        n_present  = r_present;
        n_cnt      = r_cnt;
        n_cmd      = r_cmd;
        n_id       = r_id;
        n_exp      = r_exp;
        n_pos      = r_pos;
        n_cur_id   = r_cur_id;
        n_cur_exp  = r_cur_exp;
        n_tryup    = r_tryup;
        n_oid      = r_oid;
        n_best_id  = r_best_id;
        n_best_exp = r_best_exp;
        n_best_pos = r_best_pos;
        n_has      = r_has;
        n_status   = r_status;
        n_hvalid   = r_hvalid;
        n_hid      = r_hid;
        n_hexp     = r_hexp;
        slot_we    = 1'b0;
        slot_waddr = r_pos;
        slot_wdata = r_cur_id;
        slot_raddr = '0;
        exp_we     = 1'b0;
        exp_waddr  = r_id;
        exp_wdata  = r_exp;
        exp_raddr  = r_slot_q;
        pos_we     = 1'b0;
        pos_waddr  = r_cur_id;
        pos_wdata  = r_pos;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd    = i_cmd;
                    n_id     = i_timer_id;
                    n_exp    = i_expiry;
                    n_status = ST_DONE;
                    n_state  = S_HEAD;
                    case (i_cmd)
                        CMD_INSERT: begin
                            if (r_present[i_timer_id]) begin
                                n_status = ST_PRESENT;
                            end else if (r_cnt >= CW'(MAX_TIMERS)) begin
                                n_status = ST_FULL;
                            end else begin
                                exp_we    = 1'b1;
                                exp_waddr = i_timer_id;
                                exp_wdata = i_expiry;
                                n_present[i_timer_id] = 1'b1;
                                n_cnt     = r_cnt + CW'(1);
                                n_pos     = SW'(r_cnt);
                                n_cur_id  = i_timer_id;
                                n_cur_exp = i_expiry;
                                n_tryup   = 1'b0;
                                n_state   = S_UP_A;
                            end
                        end
                        CMD_REMOVE, CMD_UPDATE: begin
                            if (!r_present[i_timer_id] || r_cnt == '0) begin
                                n_status = ST_ABSENT;
                            end else begin
                                n_state = S_POS;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_POS: begin
                n_pos = r_pos_q;
                if (r_cmd == CMD_REMOVE) begin
                    n_present[r_id] = 1'b0;
                    n_cnt = r_cnt - CW'(1);
                    if (r_pos_q < last) begin
                        slot_raddr = last;
                        n_state    = S_MVID;
                    end else begin
                        n_state = S_HEAD;
                    end
                end else if (pos_x >= cnt_x) begin
                    n_status = ST_ABSENT;
                    n_state  = S_HEAD;
                end else begin
                    exp_we    = 1'b1;
                    n_cur_id  = r_id;
                    n_cur_exp = r_exp;
                    n_state   = S_RESIFT;
                end
            end
            S_MVID: begin
                n_cur_id  = r_slot_q;
                exp_raddr = r_slot_q;
                n_state   = S_MVEXP;
            end
            S_MVEXP: begin
                n_cur_exp = r_exp_q;
                n_state   = S_RESIFT;
            end
            S_RESIFT: begin
                n_tryup = 1'b1;
                n_state = (r_pos == '0) ? S_DN_A : S_UP_A;
            end
            S_UP_A: begin
                if (r_pos == '0) begin
                    n_state = S_PLACE;
                end else begin
                    slot_raddr = parent;
                    n_state    = S_UP_B;
                end
            end
            S_UP_B: begin
                n_oid     = r_slot_q;
                exp_raddr = r_slot_q;
                n_state   = S_UP_C;
            end
            S_UP_C: begin
                if (r_cur_exp < r_exp_q) begin
                    // parent moves down into the hole
                    slot_we    = 1'b1;
                    slot_wdata = r_oid;
                    pos_we     = 1'b1;
                    pos_waddr  = r_oid;
                    n_pos      = parent;
                    n_tryup    = 1'b0;
                    n_state    = S_UP_A;
                end else begin
                    n_state = r_tryup ? S_DN_A : S_PLACE;
                end
            end
            S_DN_A: begin
                if (lft >= cnt_x) begin
                    n_state = S_PLACE;
                end else begin
                    slot_raddr = lft[SW-1:0];
                    n_state    = S_DN_B;
                end
            end
            S_DN_B: begin
                n_oid     = r_slot_q;
                exp_raddr = r_slot_q;
                n_state   = S_DN_C;
            end
            S_DN_C: begin
                if (r_exp_q < r_cur_exp) begin
                    n_best_id  = r_oid;
                    n_best_exp = r_exp_q;
                    n_best_pos = lft[SW-1:0];
                    n_has      = 1'b1;
                end else begin
                    n_best_exp = r_cur_exp;
                    n_has      = 1'b0;
                end
                if (rgt < cnt_x) begin
                    slot_raddr = rgt[SW-1:0];
                    n_state    = S_DN_D;
                end else begin
                    n_state = S_DN_F;
                end
            end
            S_DN_D: begin
                n_oid     = r_slot_q;
                exp_raddr = r_slot_q;
                n_state   = S_DN_E;
            end
            S_DN_E: begin
                if (r_exp_q < r_best_exp) begin
                    n_best_id  = r_oid;
                    n_best_exp = r_exp_q;
                    n_best_pos = rgt[SW-1:0];
                    n_has      = 1'b1;
                end
                n_state = S_DN_F;
            end
            S_DN_F: begin
                if (r_has) begin
                    // smaller child moves up into the hole
                    slot_we    = 1'b1;
                    slot_wdata = r_best_id;
                    pos_we     = 1'b1;
                    pos_waddr  = r_best_id;
                    n_pos      = r_best_pos;
                    n_state    = S_DN_A;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                slot_we = 1'b1;
                pos_we  = 1'b1;
                n_state = S_HEAD;
            end
            S_HEAD: begin
                if (r_cnt == '0) begin
                    n_hvalid = 1'b0;
                    n_hid    = '0;
                    n_hexp   = '0;
                    n_state  = S_OUT;
                end else begin
                    slot_raddr = '0;
                    n_state    = S_HEAD_B;
                end
            end
            S_HEAD_B: begin
                n_hid     = r_slot_q;
                exp_raddr = r_slot_q;
                n_state   = S_HEAD_C;
            end
            S_HEAD_C: begin
                n_hvalid = 1'b1;
                n_hexp   = r_exp_q;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        r_slot_q <= slot_mem[slot_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (exp_we) begin
            exp_mem[exp_waddr] <= exp_wdata;
        end
        r_exp_q <= exp_mem[exp_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        r_pos_q <= pos_mem[i_timer_id];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_present <= '0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_present <= n_present;
            r_cnt     <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_id       <= n_id;
        r_exp      <= n_exp;
        r_pos      <= n_pos;
        r_cur_id   <= n_cur_id;
        r_cur_exp  <= n_cur_exp;
        r_tryup    <= n_tryup;
        r_oid      <= n_oid;
        r_best_id  <= n_best_id;
        r_best_exp <= n_best_exp;
        r_best_pos <= n_best_pos;
        r_has      <= n_has;
        r_status   <= n_status;
        r_hvalid   <= n_hvalid;
        r_hid      <= n_hid;
        r_hexp     <= n_hexp;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_status      = r_status;
    assign o_head_valid  = r_hvalid;
    assign o_head_id     = r_hid;
    assign o_head_expiry = r_hexp;
    assign o_count       = r_cnt;
endmodule

@@ tb/sv/timer_min_heap_tb.sv @@
// self-checking testbench for the timer min-heap: driver, monitor, scoreboard
module timer_min_heap_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tmh_pkg::*;

    localparam int   SLOTS     = DEF_MAX_TIMERS;
    localparam t_cmd CMD_NONE  = 2'd3;
    localparam int   IDLE_LIMIT = 5000;

    typedef struct {
        t_cmd cmd;
        t_id  id;
        t_exp expiry;
        bit   wait_empty;
    } t_cmd_item;

    typedef struct {
        t_status  status;
        logic     head_valid;
        t_id      head_id;
        t_exp     head_expiry;
        logic [8:0] count;
    } t_head_report;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    t_cmd       i_cmd;
    t_id        i_timer_id;
    t_exp       i_expiry;
    logic       o_valid;
    logic       i_stall;
    t_status    o_status;
    logic       o_head_valid;
    t_id        o_head_id;
    t_exp       o_head_expiry;
    logic [8:0] o_count;

    timer_min_heap #(.MAX_TIMERS(SLOTS)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_cmd(i_cmd), .i_timer_id(i_timer_id), .i_expiry(i_expiry),
        .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
        .o_head_valid(o_head_valid), .o_head_id(o_head_id),
        .o_head_expiry(o_head_expiry), .o_count(o_count)
    );

    t_cmd_item    pending_cmds[$];
    t_head_report expected_heads[$];
    int           errors;
    int           results_seen;
    bit           rst_done;
    bit           in_accepted;
    bit           offering;
    int           send_gap;
    int           recv_gap;
    int           long_hold;
    bit           long_hold_done;
    int           idle_cycles;

    // predictor state
    t_id        heap_ids[SLOTS];
    t_exp       exp_of[256];
    int         slot_of[256];
    bit         held[256];
    int         held_n;

    // stimulus-side presence tracking
    bit         gen_held[256];
    int         gen_n;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit sorts_first(int a, int b);
        return exp_of[heap_ids[a]] < exp_of[heap_ids[b]];
    endfunction

    task automatic swap_slots(int a, int b);
        t_id ida;
        t_id idb;
        ida = heap_ids[a];
        idb = heap_ids[b];
        heap_ids[a] = idb;
        heap_ids[b] = ida;
        slot_of[idb] = a;
        slot_of[ida] = b;
    endtask

    task automatic bubble_up(int p);
        int up;
        while (p > 0) begin
            up = (p - 1) / 2;
            if (!sorts_first(p, up)) break;
            swap_slots(p, up);
            p = up;
        end
    endtask

    task automatic bubble_down(int p);
        int l;
        int best;
        forever begin
            l = 2 * p + 1;
            best = p;
            if (l < held_n && sorts_first(l, best)) best = l;
            if (l + 1 < held_n && sorts_first(l + 1, best)) best = l + 1;
            if (best == p) break;
            swap_slots(p, best);
            p = best;
        end
    endtask

    task automatic rebalance(int p);
        if (p > 0 && sorts_first(p, (p - 1) / 2)) bubble_up(p);
        else bubble_down(p);
    endtask

    task automatic apply_timer_cmd(t_cmd cmd, t_id id, t_exp ex);
        t_head_report r;
        int p;
        t_id moved;
        r.status = ST_DONE;
        case (cmd)
            CMD_INSERT: begin
                if (held[id]) r.status = ST_PRESENT;
                else if (held_n >= SLOTS) r.status = ST_FULL;
                else begin
                    held[id] = 1'b1;
                    exp_of[id] = ex;
                    slot_of[id] = held_n;
                    heap_ids[held_n] = id;
                    held_n++;
                    bubble_up(held_n - 1);
                end
            end
            CMD_REMOVE: begin
                if (!held[id] || held_n == 0) r.status = ST_ABSENT;
                else begin
                    p = slot_of[id];
                    held[id] = 1'b0;
                    held_n--;
                    // last slot is just dropped
                    if (p < held_n) begin
                        moved = heap_ids[held_n];
                        heap_ids[p] = moved;
                        slot_of[moved] = p;
                        rebalance(p);
                    end
                end
            end
            CMD_UPDATE: begin
                if (!held[id] || slot_of[id] >= held_n) r.status = ST_ABSENT;
                else begin
                    exp_of[id] = ex;
                    rebalance(slot_of[id]);
                end
            end
            default: ;
        endcase
        r.head_valid  = held_n > 0;
        r.head_id     = held_n > 0 ? heap_ids[0] : '0;
        r.head_expiry = held_n > 0 ? exp_of[heap_ids[0]] : '0;
        r.count       = held_n[8:0];
        expected_heads = {expected_heads, r};
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at result %0d: %s got %0h expected %0h",
                 results_seen, what, got, want);
        errors++;
    endtask

    function automatic int pick_gap();
        int r;
        if ((results_seen / 150) % 3 == 1) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_exp pick_expiry();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return $urandom;
        if (r < 8) return $urandom_range(0, 15);
        return r == 8 ? 32'h0 : 32'hFFFF_FFFF;
    endfunction

    function automatic t_id pick_held_id();
        t_id id;
        id = t_id'($urandom_range(0, 255));
        for (int k = 0; k < 600 && gen_n > 0 && !gen_held[id]; k++)
            id = t_id'($urandom_range(0, 255));
        return id;
    endfunction

    task automatic queue_cmd(t_cmd cmd, t_id id, t_exp ex, bit wait_empty = 0);
        t_cmd_item it;
        it.cmd = cmd;
        it.id = id;
        it.expiry = ex;
        it.wait_empty = wait_empty;
        pending_cmds = {pending_cmds, it};
        if (cmd == CMD_INSERT && !gen_held[id] && gen_n < SLOTS) begin
            gen_held[id] = 1'b1;
            gen_n++;
        end else if (cmd == CMD_REMOVE && gen_held[id]) begin
            gen_held[id] = 1'b0;
            gen_n--;
        end
    endtask

    task automatic queue_random_cmds(int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 45)
                queue_cmd(CMD_INSERT, t_id'($urandom_range(0, 255)), pick_expiry());
            else if (r < 75)
                queue_cmd(CMD_REMOVE, r < 71 ? pick_held_id() : t_id'($urandom),
                          $urandom);
            else if (r < 95)
                queue_cmd(CMD_UPDATE, r < 92 ? pick_held_id() : t_id'($urandom),
                          pick_expiry());
            else queue_cmd(CMD_NONE, t_id'($urandom), $urandom);
        end
    endtask

    // acceptance on both channels, prediction and checking
    always @(posedge i_clk) begin
        if (rst_done && i_valid && !o_stall) begin
            apply_timer_cmd(i_cmd, i_timer_id, i_expiry);
            in_accepted = 1'b1;
        end
        if (rst_done && o_valid && !i_stall) begin
            if (expected_heads.size() == 0) begin
                $display("unexpected result transaction %0d", results_seen);
                errors++;
            end else begin
                t_head_report w;
                w = expected_heads.pop_front();
                if (o_status !== w.status) report("status", o_status, w.status);
                if (o_head_valid !== w.head_valid)
                    report("head_valid", o_head_valid, w.head_valid);
                if (o_head_id !== w.head_id) report("head_id", o_head_id, w.head_id);
                if (o_head_expiry !== w.head_expiry)
                    report("head_expiry", o_head_expiry, w.head_expiry);
                if (o_count !== w.count) report("count", o_count, w.count);
            end
            results_seen++;
        end
    end

    // driver
    always @(negedge i_clk) begin
        if (rst_done) begin
            if (in_accepted) begin
                in_accepted = 1'b0;
                offering = 1'b0;
            end
            if (!offering) begin
                if (send_gap > 0) send_gap--;
                else if (pending_cmds.size() > 0 &&
                         !(pending_cmds[0].wait_empty && expected_heads.size() > 0)) begin
                    t_cmd_item it;
                    it = pending_cmds.pop_front();
                    i_cmd <= it.cmd;
                    i_timer_id <= it.id;
                    i_expiry <= it.expiry;
                    offering = 1'b1;
                    send_gap = pick_gap();
                end
            end
            i_valid <= offering;
        end
    end

    // receiver stalls, with one long hold-off once traffic is flowing
    always @(negedge i_clk) begin
        if (rst_done) begin
            if (!long_hold_done && results_seen >= 400) begin
                long_hold_done = 1'b1;
                long_hold = 300;
            end
            if (long_hold > 0) begin
                long_hold--;
                i_stall <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_stall <= 1'b1;
            end else begin
                recv_gap = pick_gap();
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("** timer_min_heap: FAILED **");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_cmd = CMD_INSERT;
        i_timer_id = '0;
        i_expiry = '0;

        // directed: empty heap, absent ids, duplicates, ties, extremes
        queue_cmd(CMD_REMOVE, 8'd5, 32'h0);
        queue_cmd(CMD_UPDATE, 8'd5, 32'h10);
        queue_cmd(CMD_NONE, 8'hA5, 32'h5A5A_5A5A);
        queue_cmd(CMD_INSERT, 8'd0, 32'hFFFF_FFFF);
        queue_cmd(CMD_INSERT, 8'd255, 32'h0);
        queue_cmd(CMD_INSERT, 8'd0, 32'h1);
        queue_cmd(CMD_INSERT, 8'd7, 32'd100);
        queue_cmd(CMD_INSERT, 8'd8, 32'd100);
        queue_cmd(CMD_UPDATE, 8'd255, 32'hFFFF_FFFF);
        queue_cmd(CMD_UPDATE, 8'd8, 32'h0);
        queue_cmd(CMD_UPDATE, 8'd7, 32'd100);
        queue_cmd(CMD_REMOVE, 8'd8, 32'h0);
        // large expiry stays in the last slot, then gets removed from there
        queue_cmd(CMD_INSERT, 8'd3, 32'hFFFF_FFFF);
        queue_cmd(CMD_REMOVE, 8'd3, 32'h0);
        queue_cmd(CMD_REMOVE, 8'd3, 32'h0);
        queue_cmd(CMD_REMOVE, 8'd0, 32'h0);
        queue_cmd(CMD_REMOVE, 8'd255, 32'h0);
        queue_cmd(CMD_REMOVE, 8'd7, 32'h0);
        queue_cmd(CMD_NONE, 8'h5A, 32'hA5A5_A5A5);

        queue_random_cmds(500);
        // fill to capacity, re-insert ids that are all held already, churn, then drain
        queue_cmd(CMD_INSERT, t_id'($urandom), pick_expiry(), 1);
        for (int k = 0; k < 256; k++)
            if (!gen_held[k] && gen_n < SLOTS) queue_cmd(CMD_INSERT, t_id'(k), pick_expiry());
        for (int k = 0; k < 4; k++) queue_cmd(CMD_INSERT, t_id'($urandom), pick_expiry());
        for (int k = 0; k < 60; k++) queue_cmd(CMD_UPDATE, t_id'($urandom), pick_expiry());
        while (gen_n > 0) queue_cmd(CMD_REMOVE, pick_held_id(), $urandom);
        queue_cmd(CMD_REMOVE, t_id'($urandom), $urandom);
        queue_random_cmds(500);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;

        wait (pending_cmds.size() == 0 && !offering && expected_heads.size() == 0);
        repeat (60) @(posedge i_clk);
        if (errors == 0 && expected_heads.size() == 0)
            $display("** timer_min_heap: PASSED **");
        else
            $display("** timer_min_heap: FAILED **");
        $finish;
    end
endmodule
